@@ design/tlca_pkg.sv @@
// Shared types and codes for the common-ancestor engine.
package tlca_pkg;

    localparam int ID_W   = 11;
    localparam int CMD_W  = 2;
    localparam int STEP_W = 5;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // register byte address
    localparam logic [1:0] ADDR_NODE_COUNT = 2'd0;

    localparam logic [STEP_W-1:0] S_IDLE  = 5'd0;
    localparam logic [STEP_W-1:0] S_CLR   = 5'd1;
    localparam logic [STEP_W-1:0] S_INIT  = 5'd2;
    localparam logic [STEP_W-1:0] S_POP   = 5'd3;
    localparam logic [STEP_W-1:0] S_POPW  = 5'd4;
    localparam logic [STEP_W-1:0] S_POPD  = 5'd5;
    localparam logic [STEP_W-1:0] S_EDGE  = 5'd6;
    localparam logic [STEP_W-1:0] S_EW    = 5'd7;
    localparam logic [STEP_W-1:0] S_VIS   = 5'd8;
    localparam logic [STEP_W-1:0] S_FRD   = 5'd9;
    localparam logic [STEP_W-1:0] S_FK    = 5'd10;
    localparam logic [STEP_W-1:0] S_FWR   = 5'd11;
    localparam logic [STEP_W-1:0] S_DONE  = 5'd12;
    localparam logic [STEP_W-1:0] S_QDA   = 5'd13;
    localparam logic [STEP_W-1:0] S_QDB   = 5'd14;
    localparam logic [STEP_W-1:0] S_QCHK  = 5'd15;
    localparam logic [STEP_W-1:0] S_LIFT  = 5'd16;
    localparam logic [STEP_W-1:0] S_LIFTW = 5'd17;
    localparam logic [STEP_W-1:0] S_UP    = 5'd18;
    localparam logic [STEP_W-1:0] S_UPW   = 5'd19;
    localparam logic [STEP_W-1:0] S_UPC   = 5'd20;
    localparam logic [STEP_W-1:0] S_PAR   = 5'd21;
    localparam logic [STEP_W-1:0] S_PARW  = 5'd22;
    localparam logic [STEP_W-1:0] S_RES   = 5'd23;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  node_a;
        logic [ID_W-1:0]  node_b;
    } item_t;

    typedef struct packed {
        logic [ID_W-1:0] ancestor;
        logic            error;
    } result_t;

    typedef struct packed {
        logic [STEP_W-1:0] step;
    } ctl_t;

    typedef struct packed {
        logic q_empty;
        logic edge_end;
        logic match;
        logic last_node;
        logic last_level;
        logic no_fill;
        logic k_zero;
        logic lift_end;
        logic lift_bit;
        logic same_uv;
        logic lvl_zero;
        logic qry_err;
        logic out_free;
    } sts_t;

endpackage

@@ design/tlca_ram.sv @@
// Generic simple dual-port RAM with registered read.
module tlca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ design/tlca_ctrl.sv @@
// Sequencer for load, build and query.
module tlca_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  logic [tlca_pkg::CMD_W-1:0]  item_cmd,
    output logic                        item_stall,
    input  tlca_pkg::sts_t              sts,
    output tlca_pkg::ctl_t              ctl
);
    import tlca_pkg::*;

    logic [STEP_W-1:0] state_reg, state_next;
    logic [STEP_W-1:0] fill_next;

    assign item_stall = (state_reg != S_IDLE);
    assign ctl.step   = state_reg;
    assign fill_next  = (sts.last_node && sts.last_level) ? S_DONE : S_FRD;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    case (item_cmd)
                        CMD_BUILD: state_next = S_CLR;
                        CMD_QUERY: state_next = S_QDA;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_CLR:   state_next = sts.last_node ? S_INIT : S_CLR;
            S_INIT:  state_next = S_POP;
            S_POP:
            begin
                if (sts.q_empty)
                    state_next = sts.no_fill ? S_DONE : S_FRD;
                else
                    state_next = S_POPW;
            end
            S_POPW:  state_next = S_POPD;
            S_POPD:  state_next = S_EDGE;
            S_EDGE:  state_next = sts.edge_end ? S_POP : S_EW;
            S_EW:    state_next = sts.match ? S_VIS : S_EDGE;
            S_VIS:   state_next = S_EDGE;
            S_FRD:   state_next = S_FK;
            S_FK:    state_next = sts.k_zero ? fill_next : S_FWR;
            S_FWR:   state_next = fill_next;
            S_DONE:  state_next = S_IDLE;
            S_QDA:   state_next = S_QDB;
            S_QDB:   state_next = S_QCHK;
            S_QCHK:  state_next = sts.qry_err ? S_RES : S_LIFT;
            S_LIFT:
            begin
                if (sts.lift_end)
                    state_next = sts.same_uv ? S_RES : S_UP;
                else if (sts.lift_bit)
                    state_next = S_LIFTW;
                else
                    state_next = S_LIFT;
            end
            S_LIFTW: state_next = S_LIFT;
            S_UP:    state_next = S_UPW;
            S_UPW:   state_next = S_UPC;
            S_UPC:   state_next = sts.lvl_zero ? S_PAR : S_UP;
            S_PAR:   state_next = S_PARW;
            S_PARW:  state_next = S_RES;
            S_RES:   state_next = sts.out_free ? S_IDLE : S_RES;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

@@ design/tlca_dp.sv @@
// Datapath: edge, depth, queue and ancestor stores plus walk and query registers.
module tlca_dp #(
    parameter int MAX_NODES  = 1024,
    parameter int LOG_LEVELS = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tlca_pkg::ctl_t    ctl,
    output tlca_pkg::sts_t    sts,
    input  logic              item_valid,
    input  tlca_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output tlca_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import tlca_pkg::*;

    localparam int CW   = $clog2(MAX_NODES + 1);
    localparam int EDEP = MAX_NODES - 1;
    localparam int EAW  = $clog2(EDEP > 1 ? EDEP : 2);
    localparam int QAW  = $clog2(MAX_NODES);
    localparam int ADEP = LOG_LEVELS * (MAX_NODES + 1);
    localparam int AAW  = $clog2(ADEP);
    localparam int LW   = $clog2(LOG_LEVELS + 1);

    // edge store
    logic               e_we;
    logic [EAW-1:0]     e_waddr, e_raddr;
    logic [2*ID_W-1:0]  e_wdata, e_rdata;
    // depth store
    logic               d_we;
    logic [CW-1:0]      d_waddr, d_raddr;
    logic [CW-1:0]      d_wdata, d_rdata;
    // visit queue
    logic               q_we;
    logic [QAW-1:0]     q_waddr, q_raddr;
    logic [ID_W-1:0]    q_wdata, q_rdata;
    // ancestor table
    logic               a_we;
    logic [AAW-1:0]     a_waddr, a_raddr;
    logic [ID_W-1:0]    a_wdata, a_rdata;

    logic [ID_W-1:0] nc_reg, nc_next;
    logic [CW-1:0]   et_reg, et_next;
    logic            ready_reg, ready_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [LW-1:0]   lvl_reg, lvl_next;
    logic [CW-1:0]   qh_reg, qh_next;
    logic [CW-1:0]   qt_reg, qt_next;
    logic            rv_reg, rv_next;

    logic [ID_W-1:0] cur_reg, cur_next;
    logic [CW-1:0]   cdep_reg, cdep_next;
    logic [ID_W-1:0] to_reg, to_next;
    logic [ID_W-1:0] a_reg, a_next;
    logic [ID_W-1:0] b_reg, b_next;
    logic [CW-1:0]   da_reg, da_next;
    logic [ID_W-1:0] u_reg, u_next;
    logic [ID_W-1:0] v_reg, v_next;
    logic [CW-1:0]   diff_reg, diff_next;
    logic [ID_W-1:0] au_reg, au_next;
    logic [ID_W-1:0] ra_reg, ra_next;
    logic            re_reg, re_next;
    result_t         rout_reg, rout_next;

    logic [ID_W-1:0] e_first, e_second, to_c, cfg_v;
    logic            match_c, qry_err_c, out_free_c;

    function automatic logic [AAW-1:0] anc_at(input logic [LW-1:0] l,
                                              input logic [ID_W-1:0] n);
        return AAW'(l * (MAX_NODES + 1)) + AAW'(n);
    endfunction

    function automatic logic id_ok(input logic [ID_W-1:0] n,
                                   input logic [ID_W-1:0] lim);
        return (n != '0) && (n <= lim);
    endfunction

    tlca_ram #(.WIDTH(2*ID_W), .DEPTH(EDEP)) u_edge (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata));
    tlca_ram #(.WIDTH(CW), .DEPTH(MAX_NODES + 1)) u_depth (
        .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .raddr(d_raddr), .rdata(d_rdata));
    tlca_ram #(.WIDTH(ID_W), .DEPTH(MAX_NODES)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata));
    tlca_ram #(.WIDTH(ID_W), .DEPTH(ADEP)) u_anc (
        .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
        .raddr(a_raddr), .rdata(a_rdata));

    assign e_first    = e_rdata[2*ID_W-1:ID_W];
    assign e_second   = e_rdata[ID_W-1:0];
    assign match_c    = (e_first == cur_reg) || (e_second == cur_reg);
    assign to_c       = (e_first == cur_reg) ? e_second : e_first;
    assign qry_err_c  = !ready_reg || !id_ok(a_reg, nc_reg) || !id_ok(b_reg, nc_reg)
                        || (da_reg == '0) || (d_rdata == '0);
    assign out_free_c = !rv_reg || !result_stall;

    assign sts.q_empty    = (qh_reg == qt_reg);
    assign sts.edge_end   = (cnt_reg == et_reg);
    assign sts.match      = match_c;
    assign sts.last_node  = (cnt_reg == CW'(MAX_NODES));
    assign sts.last_level = (32'(lvl_reg) + 2 == LOG_LEVELS);
    assign sts.no_fill    = (LOG_LEVELS < 2);
    assign sts.k_zero     = (a_rdata == '0);
    assign sts.lift_end   = (32'(lvl_reg) == LOG_LEVELS);
    assign sts.lift_bit   = ((diff_reg >> lvl_reg) & CW'(1)) != '0;
    assign sts.same_uv    = (u_reg == v_reg);
    assign sts.lvl_zero   = (lvl_reg == '0);
    assign sts.qry_err    = qry_err_c;
    assign sts.out_free   = out_free_c;

    assign result_valid = rv_reg;
    assign result       = rout_reg;
    assign pready       = 1'b1;
    assign prdata       = 32'(nc_reg);

    // clamp a written node count to 1..MAX_NODES
    always_comb
    begin
        cfg_v = pwdata[ID_W-1:0];
        if (cfg_v == '0)
            cfg_v = ID_W'(1);
        else if (32'(cfg_v) > MAX_NODES)
            cfg_v = ID_W'(MAX_NODES);
    end

    always_comb
    begin
        e_we = 1'b0; e_waddr = EAW'(et_reg); e_wdata = {item.node_a, item.node_b};
        e_raddr = EAW'(cnt_reg);
        d_we = 1'b0; d_waddr = '0; d_wdata = '0; d_raddr = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = QAW'(qh_reg);
        a_we = 1'b0; a_waddr = '0; a_wdata = '0; a_raddr = '0;

        nc_next = nc_reg; et_next = et_reg; ready_next = ready_reg;
        cnt_next = cnt_reg; lvl_next = lvl_reg; qh_next = qh_reg; qt_next = qt_reg;
        rv_next = rv_reg && result_stall;
        cur_next = cur_reg; cdep_next = cdep_reg; to_next = to_reg;
        a_next = a_reg; b_next = b_reg; da_next = da_reg;
        u_next = u_reg; v_next = v_reg; diff_next = diff_reg; au_next = au_reg;
        ra_next = ra_reg; re_next = re_reg; rout_next = rout_reg;

        if (psel && penable && pwrite && paddr == ADDR_NODE_COUNT)
            nc_next = cfg_v;

        unique case (ctl.step) inside
            S_IDLE:
            begin
                if (item_valid)
                begin
                    a_next   = item.node_a;
                    b_next   = item.node_b;
                    cnt_next = '0;
                    if (item.cmd == CMD_LOAD && id_ok(item.node_a, nc_reg)
                        && id_ok(item.node_b, nc_reg) && 32'(et_reg) < EDEP)
                    begin
                        e_we    = 1'b1;
                        et_next = et_reg + CW'(1);
                    end
                end
            end
            S_CLR:
            begin
                d_we = 1'b1; d_waddr = cnt_reg;
                a_we = 1'b1; a_waddr = anc_at(LW'(0), ID_W'(cnt_reg));
                cnt_next = cnt_reg + CW'(1);
            end
            S_INIT:
            begin
                d_we = 1'b1; d_waddr = CW'(1); d_wdata = CW'(1);
                q_we = 1'b1; q_waddr = '0; q_wdata = ID_W'(1);
                qh_next = '0; qt_next = CW'(1);
            end
            S_POP:
            begin
                if (qh_reg == qt_reg)
                begin
                    cnt_next = CW'(1);
                    lvl_next = '0;
                end
                else
                    qh_next = qh_reg + CW'(1);
            end
            S_POPW:
            begin
                cur_next = q_rdata;
                d_raddr  = CW'(q_rdata);
            end
            S_POPD:
            begin
                cdep_next = d_rdata;
                cnt_next  = '0;
            end
            S_EDGE: ;
            S_EW:
            begin
                to_next = to_c;
                if (match_c)
                    d_raddr = CW'(to_c);
                else
                    cnt_next = cnt_reg + CW'(1);
            end
            S_VIS:
            begin
                // newly reached: record depth, parent, and enqueue
                if (id_ok(to_reg, nc_reg) && d_rdata == '0)
                begin
                    d_we = 1'b1; d_waddr = CW'(to_reg); d_wdata = cdep_reg + CW'(1);
                    a_we = 1'b1; a_waddr = anc_at(LW'(0), to_reg); a_wdata = cur_reg;
                    q_we = 1'b1; q_waddr = QAW'(qt_reg); q_wdata = to_reg;
                    qt_next = qt_reg + CW'(1);
                end
                cnt_next = cnt_reg + CW'(1);
            end
            S_FRD:
                a_raddr = anc_at(lvl_reg, ID_W'(cnt_reg));
            S_FK, S_FWR:
            begin
                if (ctl.step == S_FK && a_rdata != '0)
                    a_raddr = anc_at(lvl_reg, a_rdata);
                else
                begin
                    a_we    = 1'b1;
                    a_waddr = anc_at(lvl_reg + LW'(1), ID_W'(cnt_reg));
                    a_wdata = (ctl.step == S_FK) ? '0 : a_rdata;
                    if (cnt_reg == CW'(MAX_NODES))
                    begin
                        cnt_next = CW'(1);
                        lvl_next = lvl_reg + LW'(1);
                    end
                    else
                        cnt_next = cnt_reg + CW'(1);
                end
            end
            S_DONE:
                ready_next = 1'b1;
            S_QDA:
                d_raddr = CW'(a_reg);
            S_QDB:
            begin
                da_next = d_rdata;
                d_raddr = CW'(b_reg);
            end
            S_QCHK:
            begin
                lvl_next = '0;
                if (qry_err_c)
                begin
                    ra_next = '0;
                    re_next = 1'b1;
                end
                else if (da_reg > d_rdata)
                begin
                    u_next = b_reg; v_next = a_reg; diff_next = da_reg - d_rdata;
                end
                else
                begin
                    u_next = a_reg; v_next = b_reg; diff_next = d_rdata - da_reg;
                end
            end
            S_LIFT:
            begin
                if (32'(lvl_reg) == LOG_LEVELS)
                begin
                    ra_next  = u_reg;
                    re_next  = 1'b0;
                    lvl_next = LW'(LOG_LEVELS - 1);
                end
                else if (sts.lift_bit)
                    a_raddr = anc_at(lvl_reg, v_reg);
                else
                    lvl_next = lvl_reg + LW'(1);
            end
            S_LIFTW:
            begin
                v_next   = a_rdata;
                lvl_next = lvl_reg + LW'(1);
            end
            S_UP:
                a_raddr = anc_at(lvl_reg, u_reg);
            S_UPW:
            begin
                au_next = a_rdata;
                a_raddr = anc_at(lvl_reg, v_reg);
            end
            S_UPC:
            begin
                if (au_reg != a_rdata)
                begin
                    u_next = au_reg;
                    v_next = a_rdata;
                end
                if (lvl_reg != '0)
                    lvl_next = lvl_reg - LW'(1);
            end
            S_PAR:
                a_raddr = anc_at(LW'(0), u_reg);
            S_PARW:
            begin
                ra_next = a_rdata;
                re_next = 1'b0;
            end
            S_RES:
            begin
                if (out_free_c)
                begin
                    rv_next            = 1'b1;
                    rout_next.ancestor = ra_reg;
                    rout_next.error    = re_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg    <= ID_W'(1);
            et_reg    <= '0;
            ready_reg <= 1'b0;
            cnt_reg   <= '0;
            lvl_reg   <= '0;
            qh_reg    <= '0;
            qt_reg    <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            nc_reg    <= nc_next;
            et_reg    <= et_next;
            ready_reg <= ready_next;
            cnt_reg   <= cnt_next;
            lvl_reg   <= lvl_next;
            qh_reg    <= qh_next;
            qt_reg    <= qt_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        cdep_reg <= cdep_next;
        to_reg   <= to_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        da_reg   <= da_next;
        u_reg    <= u_next;
        v_reg    <= v_next;
        diff_reg <= diff_next;
        au_reg   <= au_next;
        ra_reg   <= ra_next;
        re_reg   <= re_next;
        rout_reg <= rout_next;
    end

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        qh_reg <= qt_reg && 32'(qt_reg) <= MAX_NODES)
        else $error("visit queue pointers out of order");

    a_edge_cap: assert property (@(posedge clk) disable iff (!rst_n)
        32'(et_reg) <= EDEP)
        else $error("edge count beyond store");

    a_res_load: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.step == S_RES && out_free_c) |=> rv_reg)
        else $error("result beat not loaded");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rv_reg && rout_reg.error) |-> (rout_reg.ancestor == '0))
        else $error("error beat with nonzero ancestor");
endmodule

@@ design/tree_lca_binary_lifting.sv @@
// Lowest common ancestor engine on a tree rooted at node 1, using a doubling
// ancestor table. One item is handled at a time; each memory has one read and
// one write port and that port sets the timing. A load stores one edge. A query
// lifts the deeper node by the depth difference, then, unless the two meet,
// descends over all levels, and then waits on the output handshake. A build
// clears the depths of all MAX_NODES+1 node slots, then visits each reached
// node and scans every stored edge for it, then fills each of LOG_LEVELS-1
// table levels node slot by node slot.
// Queries before the first build return the error flag.
module tree_lca_binary_lifting #(
    parameter int MAX_NODES  = 1024,
    parameter int LOG_LEVELS = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  tlca_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output tlca_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import tlca_pkg::*;

    ctl_t ctl;
    sts_t sts;

    tlca_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .item_valid(item_valid), .item_cmd(item.cmd),
        .item_stall(item_stall), .sts(sts), .ctl(ctl));

    tlca_dp #(.MAX_NODES(MAX_NODES), .LOG_LEVELS(LOG_LEVELS)) u_dp (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
        .item_valid(item_valid), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready));
endmodule
